// ===== src/e2c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared constants, tables and types of the Unix time to UTC date converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

    // Pipeline depth from input register to output register
    localparam int NUM_STAGES = 9;

    // Seconds from 1970-01-01 to 2000-01-01
    localparam logic [31:0] SECONDS_TO_2000 = 32'd946684800;

    // Days in one four-year cycle
    localparam logic [10:0] CYCLE_DAYS = 11'd1461;

    // Day count of 2100-03-01; the missing leap day is inserted from here on
    localparam logic [15:0] MARCH_FIRST_2100 = 16'd36584;

    // Reciprocal constants: x/15 = (x * DIV15_MUL) >> 35, x/3 = (x * DIV3_MUL) >> 33
    localparam logic [31:0] DIV15_MUL = 32'h8888_8889;
    localparam logic [31:0] DIV3_MUL  = 32'hAAAA_AAAB;

    // d/1461 = (d * CYCLE_MUL) >> 26 for every 16-bit day count
    localparam logic [15:0] CYCLE_MUL = 16'd45934;

    // First day of each month, counted from the start of the four-year cycle
    localparam logic [0:3][0:11][10:0] MONTH_START = '{
        '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
          11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
        '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
          11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
        '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
          11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
        '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
          11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
    };

    // Time-of-day fields carried down the pipeline
    typedef struct packed {
        logic       oor;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
    } tod_t;

endpackage

// ===== src/e2c_month_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_month_find
// Locates the month within a year of the four-year cycle and the day in it.
// ----------------------------------------------------------------------------
module e2c_month_find (
    input  logic [10:0] day_in_cycle,
    input  logic [1:0]  year_in_cycle,
    output logic [3:0]  month_idx,
    output logic [4:0]  day_of_month
);

    logic [11:0] past_start;
    logic [10:0] start_day;

    always_comb begin
        for (int m = 0; m < 12; m++) begin
            past_start[m] = (day_in_cycle >= e2c_pkg::MONTH_START[year_in_cycle][m]);
        end
    end

    // Take the last month whose first day is not after the day
    always_comb begin
        month_idx = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (past_start[m]) begin
                month_idx = 4'(m);
            end
        end
    end

    always_comb begin
        start_day    = e2c_pkg::MONTH_START[year_in_cycle][month_idx];
        day_of_month = 5'(day_in_cycle - start_day + 11'd1);
    end

endmodule

// ===== src/epoch_to_calendar_date_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_core
// Converts a 32-bit Unix timestamp into UTC second, minute, hour, day, month
// and year since 2000, with an out-of-range flag for times before 2000.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: s_epoch_seconds on s_valid/s_ready. Output word: the date and
//   time fields plus m_out_of_range on m_valid/m_ready. Each input word gives
//   exactly one output word, in order.
//   The converter is a nine-stage pipeline: an accepted word passes through
//   the stages in order to the output register, and a new word can be
//   accepted every cycle unless the full pipeline is stalled by m_ready.
//   Each stage holds at most one multiplication by a reciprocal constant
//   (divide by 60 twice, by 24, by 1461) or one table compare step.
//   When m_ready is low the output word holds; upstream stages keep filling
//   empty slots, and s_ready drops only once every stage holds a word.
//   Reset (aresetn low at a clock edge) empties the pipeline; no words are
//   in flight afterwards. Timestamps before 2000-01-01 give out_of_range = 1
//   and all other fields zero.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_second_of_minute,
    output logic [5:0]  m_minute_of_hour,
    output logic [4:0]  m_hour_of_day,
    output logic [4:0]  m_day_of_month,
    output logic [3:0]  m_month_of_year,
    output logic [6:0]  m_years_since_2000,
    output logic        m_out_of_range
);

    localparam int NS = e2c_pkg::NUM_STAGES;

    logic [NS:1] vld_reg;
    logic [NS:1] rdy;
    logic [NS:1] vld_in;

    // Stage payloads
    logic [31:0]     s1_t_reg;
    e2c_pkg::tod_t   s1_tod_reg;
    logic [31:0]     s2_t_reg;
    logic [61:0]     s2_p_reg;
    e2c_pkg::tod_t   s2_tod_reg;
    logic [5:0]      s3_q1lo_reg;
    logic [56:0]     s3_p_reg;
    e2c_pkg::tod_t   s3_tod_reg;
    logic [4:0]      s4_q2lo_reg;
    logic [50:0]     s4_p_reg;
    e2c_pkg::tod_t   s4_tod_reg;
    logic [15:0]     s5_d_reg;
    e2c_pkg::tod_t   s5_tod_reg;
    logic [15:0]     s6_d_reg;
    logic [31:0]     s6_p_reg;
    e2c_pkg::tod_t   s6_tod_reg;
    logic [4:0]      s7_cyc_reg;
    logic [10:0]     s7_r_reg;
    e2c_pkg::tod_t   s7_tod_reg;
    logic [4:0]      s8_cyc_reg;
    logic [1:0]      s8_yr_reg;
    logic [10:0]     s8_r_reg;
    e2c_pkg::tod_t   s8_tod_reg;
    e2c_pkg::tod_t   out_tod_reg;
    logic [4:0]      out_day_reg;
    logic [3:0]      out_month_reg;
    logic [6:0]      out_year_reg;

    // Stage logic
    logic [26:0] q1;
    logic [21:0] q2;
    logic [15:0] d_div;
    logic [15:0] d_next;
    logic [4:0]  cyc;
    logic [10:0] r_next;
    logic [1:0]  yr_next;
    logic [3:0]  month_idx;
    logic [4:0]  dom;

    // A stage takes a new word when empty or when its word moves on
    always_comb begin
        rdy[NS] = !vld_reg[NS] || m_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k + 1];
        end
        vld_in = {vld_reg[NS-1:1], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_comb begin
        q1     = s2_p_reg[61:35];
        q2     = s3_p_reg[56:35];
        d_div  = s4_p_reg[48:33];
        d_next = d_div + 16'(d_div >= e2c_pkg::MARCH_FIRST_2100);
        cyc    = s6_p_reg[30:26];
        r_next = 11'(s6_d_reg - 16'(cyc * e2c_pkg::CYCLE_DAYS));
        if (s7_r_reg >= e2c_pkg::MONTH_START[3][0]) begin
            yr_next = 2'd3;
        end else if (s7_r_reg >= e2c_pkg::MONTH_START[2][0]) begin
            yr_next = 2'd2;
        end else if (s7_r_reg >= e2c_pkg::MONTH_START[1][0]) begin
            yr_next = 2'd1;
        end else begin
            yr_next = 2'd0;
        end
    end

    e2c_month_find u_month_find (
        .day_in_cycle  (s8_r_reg),
        .year_in_cycle (s8_yr_reg),
        .month_idx     (month_idx),
        .day_of_month  (dom)
    );

    always_ff @(posedge aclk) begin
        // Offset to 2000 and range check
        if (rdy[1]) begin
            s1_t_reg   <= s_epoch_seconds - e2c_pkg::SECONDS_TO_2000;
            s1_tod_reg <= '{oor: (s_epoch_seconds < e2c_pkg::SECONDS_TO_2000),
                            sec: 6'd0, min: 6'd0, hr: 5'd0};
        end
        // t / 60 as (t / 4) / 15
        if (rdy[2]) begin
            s2_t_reg   <= s1_t_reg;
            s2_p_reg   <= 62'(s1_t_reg[31:2]) * 62'(e2c_pkg::DIV15_MUL);
            s2_tod_reg <= s1_tod_reg;
        end
        // Seconds; minutes quotient
        if (rdy[3]) begin
            s3_tod_reg  <= '{oor: s2_tod_reg.oor,
                             sec: s2_t_reg[5:0] - 6'(q1[5:0] * 6'd60),
                             min: s2_tod_reg.min,
                             hr:  s2_tod_reg.hr};
            s3_q1lo_reg <= q1[5:0];
            s3_p_reg    <= 57'(q1[26:2]) * 57'(e2c_pkg::DIV15_MUL);
        end
        // Minutes; hours quotient as (q / 8) / 3
        if (rdy[4]) begin
            s4_tod_reg  <= '{oor: s3_tod_reg.oor,
                             sec: s3_tod_reg.sec,
                             min: s3_q1lo_reg - 6'(q2[5:0] * 6'd60),
                             hr:  s3_tod_reg.hr};
            s4_q2lo_reg <= q2[4:0];
            s4_p_reg    <= 51'(q2[21:3]) * 51'(e2c_pkg::DIV3_MUL);
        end
        // Hours; day count with the 2100 correction
        if (rdy[5]) begin
            s5_tod_reg <= '{oor: s4_tod_reg.oor,
                            sec: s4_tod_reg.sec,
                            min: s4_tod_reg.min,
                            hr:  s4_q2lo_reg - 5'(d_div[1:0] * 5'd24)};
            s5_d_reg   <= d_next;
        end
        // Four-year cycle quotient
        if (rdy[6]) begin
            s6_tod_reg <= s5_tod_reg;
            s6_d_reg   <= s5_d_reg;
            s6_p_reg   <= 32'(s5_d_reg) * 32'(e2c_pkg::CYCLE_MUL);
        end
        // Day within the cycle
        if (rdy[7]) begin
            s7_tod_reg <= s6_tod_reg;
            s7_cyc_reg <= cyc;
            s7_r_reg   <= r_next;
        end
        // Year within the cycle
        if (rdy[8]) begin
            s8_tod_reg <= s7_tod_reg;
            s8_cyc_reg <= s7_cyc_reg;
            s8_yr_reg  <= yr_next;
            s8_r_reg   <= s7_r_reg;
        end
        // Month and day; zero everything for times before 2000
        if (rdy[9]) begin
            if (s8_tod_reg.oor) begin
                out_tod_reg     <= '{oor: 1'b1, sec: 6'd0, min: 6'd0, hr: 5'd0};
                out_day_reg     <= '0;
                out_month_reg   <= '0;
                out_year_reg    <= '0;
            end else begin
                out_tod_reg     <= s8_tod_reg;
                out_day_reg     <= dom;
                out_month_reg   <= month_idx + 4'd1;
                out_year_reg    <= {s8_cyc_reg, s8_yr_reg};
            end
        end
    end

    assign s_ready            = rdy[1];
    assign m_valid            = vld_reg[NS];
    assign m_second_of_minute = out_tod_reg.sec;
    assign m_minute_of_hour   = out_tod_reg.min;
    assign m_hour_of_day      = out_tod_reg.hr;
    assign m_day_of_month     = out_day_reg;
    assign m_month_of_year    = out_month_reg;
    assign m_years_since_2000 = out_year_reg;
    assign m_out_of_range     = out_tod_reg.oor;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |->
            m_second_of_minute == 6'd0 && m_minute_of_hour == 6'd0 &&
            m_hour_of_day == 5'd0 && m_day_of_month == 5'd0 &&
            m_month_of_year == 4'd0 && m_years_since_2000 == 7'd0)
        else $error("out-of-range word carries nonzero fields");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |->
            m_second_of_minute < 6'd60 && m_minute_of_hour < 6'd60 &&
            m_hour_of_day < 5'd24)
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |->
            m_month_of_year >= 4'd1 && m_month_of_year <= 4'd12 &&
            m_day_of_month >= 5'd1 && m_years_since_2000 <= 7'd106)
        else $error("calendar date out of range");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] && !rdy[1] |=> vld_reg[1] && $stable(s1_t_reg) &&
            $stable(s1_tod_reg))
        else $error("stalled first stage lost its word");
`endif

endmodule

// ===== tb/epoch_date_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_date_checker
// Watches the timestamp and date channels of the converter. For every
// timestamp word it computes the expected UTC date and time, queues it, and
// compares each date word on the output against the oldest queued one.
// ----------------------------------------------------------------------------
module epoch_date_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [5:0]  m_second_of_minute,
    input  logic [5:0]  m_minute_of_hour,
    input  logic [4:0]  m_hour_of_day,
    input  logic [4:0]  m_day_of_month,
    input  logic [3:0]  m_month_of_year,
    input  logic [6:0]  m_years_since_2000,
    input  logic        m_out_of_range,
    output int          mismatches,
    output int          outstanding,
    output int          dates_seen,
    output int          early_seen,
    output int          late_seen
);

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic       oor;
    } date_word_t;

    date_word_t  pending_dates[$];

    // first day of each month, counted from the start of a four-year cycle
    int unsigned first_day [0:3][0:11];

    initial begin : build_table
        int unsigned acc;
        int unsigned len;
        acc = 0;
        for (int y = 0; y < 4; y++) begin
            for (int m = 0; m < 12; m++) begin
                first_day[y][m] = acc;
                if (m == 1) begin
                    len = (y == 0) ? 29 : 28;
                end else if (m == 3 || m == 5 || m == 8 || m == 10) begin
                    len = 30;
                end else begin
                    len = 31;
                end
                acc += len;
            end
        end
    end

    function automatic date_word_t calendar_of(input logic [31:0] stamp);
        date_word_t  w;
        int unsigned t;
        int unsigned days;
        int unsigned rem;
        int unsigned yr;
        int unsigned mo;
        w = '0;
        if (stamp < e2c_pkg::SECONDS_TO_2000) begin
            w.oor = 1'b1;
            return w;
        end
        t     = stamp - e2c_pkg::SECONDS_TO_2000;
        w.sec = 6'(t % 60);
        t     = t / 60;
        w.min = 6'(t % 60);
        t     = t / 60;
        w.hr  = 5'(t % 24);
        days  = t / 24;
        // 2100 is no leap year: skip the table's Feb 29 from March 2100 on
        if (days >= e2c_pkg::MARCH_FIRST_2100)
            days++;
        rem = days % e2c_pkg::CYCLE_DAYS;
        yr  = 3;
        while (yr > 0 && rem < first_day[yr][0])
            yr--;
        mo = 11;
        while (mo > 0 && rem < first_day[yr][mo])
            mo--;
        w.day   = 5'(rem - first_day[yr][mo] + 1);
        w.month = 4'(mo + 1);
        w.year  = 7'((days / e2c_pkg::CYCLE_DAYS) * 4 + yr);
        return w;
    endfunction

    always @(posedge aclk) begin : watch
        date_word_t want;
        date_word_t got;
        if (!aresetn) begin
            pending_dates.delete();
            mismatches  = 0;
            outstanding = 0;
            dates_seen  = 0;
            early_seen  = 0;
            late_seen   = 0;
        end else begin
            if (s_valid && s_ready)
                pending_dates.push_back(calendar_of(s_epoch_seconds));
            if (m_valid && m_ready) begin
                got = '{m_second_of_minute, m_minute_of_hour, m_hour_of_day,
                        m_day_of_month, m_month_of_year, m_years_since_2000,
                        m_out_of_range};
                if (pending_dates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: date word with none pending:",
                                  " %0d-%0d-%0d %0d:%0d:%0d oor=%0d"},
                                 $realtime, got.year, got.month, got.day,
                                 got.hr, got.min, got.sec, got.oor);
                end else begin
                    want = pending_dates.pop_front();
                    dates_seen++;
                    if (want.oor)
                        early_seen++;
                    else if (want.year >= 7'd100)
                        late_seen++;
                    if (got.sec !== want.sec || got.min !== want.min ||
                        got.hr !== want.hr || got.day !== want.day ||
                        got.month !== want.month || got.year !== want.year ||
                        got.oor !== want.oor) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d",
                                      " oor=%0d, got %0d-%0d-%0d %0d:%0d:%0d oor=%0d"},
                                     $realtime, want.year, want.month, want.day,
                                     want.hr, want.min, want.sec, want.oor,
                                     got.year, got.month, got.day,
                                     got.hr, got.min, got.sec, got.oor);
                    end
                end
            end
            outstanding = pending_dates.size();
        end
    end

endmodule

// ===== tb/epoch_to_calendar_date_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_core_test
// Drives timestamps into the converter: boundary cases first (before 2000,
// leap days, cycle ends, the 2100 correction, the 32-bit limit), a full drain,
// a long output stall, random words with random gaps and output stalls, a
// final stretch at full rate and a drain. The checker does the comparing.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date_core_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;
    localparam int RANDOM_WORDS = 990;
    localparam int STEADY_WORDS = 100;
    localparam int LAST_DAY     = 38753;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_epoch_seconds;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_second_of_minute;
    logic [5:0]  m_minute_of_hour;
    logic [4:0]  m_hour_of_day;
    logic [4:0]  m_day_of_month;
    logic [3:0]  m_month_of_year;
    logic [6:0]  m_years_since_2000;
    logic        m_out_of_range;

    int          mismatches;
    int          outstanding;
    int          dates_seen;
    int          early_seen;
    int          late_seen;
    int          cycle_count = 0;
    bit          calm;
    bit          long_hold;

    epoch_to_calendar_date_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_second_of_minute (m_second_of_minute),
        .m_minute_of_hour   (m_minute_of_hour),
        .m_hour_of_day      (m_hour_of_day),
        .m_day_of_month     (m_day_of_month),
        .m_month_of_year    (m_month_of_year),
        .m_years_since_2000 (m_years_since_2000),
        .m_out_of_range     (m_out_of_range)
    );

    epoch_date_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_second_of_minute (m_second_of_minute),
        .m_minute_of_hour   (m_minute_of_hour),
        .m_hour_of_day      (m_hour_of_day),
        .m_day_of_month     (m_day_of_month),
        .m_month_of_year    (m_month_of_year),
        .m_years_since_2000 (m_years_since_2000),
        .m_out_of_range     (m_out_of_range),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .dates_seen         (dates_seen),
        .early_seen         (early_seen),
        .late_seen          (late_seen)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // timestamp of a given day after 2000-01-01 plus some seconds
    function automatic logic [31:0] stamp_at(input int day, input int secs);
        return 32'(longint'(e2c_pkg::SECONDS_TO_2000) + longint'(day) * 86400 + secs);
    endfunction

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return $urandom_range(32'hFFFF_FFFF, e2c_pkg::SECONDS_TO_2000);
            7:          return $urandom_range(e2c_pkg::SECONDS_TO_2000 - 1, 0);
            // straddle a midnight, where day and month roll over
            default:    return stamp_at($urandom_range(0, LAST_DAY), 0)
                               - $urandom_range(0, 1);
        endcase
    endfunction

    // hold the word until accepted, then maybe drop valid for a burst
    task automatic offer(input logic [31:0] stamp);
        int gap;
        s_valid         <= 1'b1;
        s_epoch_seconds <= stamp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic drain();
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    // output side: random stall bursts, one long hold on request
    initial begin : receiver
        int span;
        bit long_done;
        m_ready   = 1'b0;
        long_done = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (long_hold && !long_done) begin
                m_ready   <= 1'b0;
                span      = LONG_HOLD;
                long_done = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                span    = $urandom_range(1, 13);
            end else begin
                m_ready <= 1'b1;
                span    = $urandom_range(1, 20);
            end
            repeat (span) @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [31:0] directed[$];
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_epoch_seconds = '0;
        calm            = 1'b0;
        long_hold       = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed = '{
            32'h0000_0000, 32'h0000_0001,
            stamp_at(0, -1), stamp_at(0, 0), stamp_at(0, 1),
            stamp_at(59, 0), stamp_at(60, 0),           // 2000-02-29, 2000-03-01
            stamp_at(366, -1), stamp_at(366, 0),        // end of the leap year
            stamp_at(1461, -1), stamp_at(1461, 0),      // end of a four-year cycle
            stamp_at(35123, 43199),                     // 2096-02-29 11:59:59
            stamp_at(36584, -1), stamp_at(36584, 0),    // 2100-02-28 / 2100-03-01
            stamp_at(36890, -1), stamp_at(36890, 0),    // end of 2100
            32'h7FFF_FFFF, 32'h8000_0000,
            32'h5A5A_5A5A, 32'hA5A5_A5A5,
            32'hFFFF_FFFE, 32'hFFFF_FFFF
        };
        foreach (directed[i])
            offer(directed[i]);

        // pause until the pipeline is empty
        s_valid <= 1'b0;
        drain();

        // keep offering while the output holds off, so the input stalls
        calm      = 1'b1;
        long_hold = 1'b1;
        repeat (40)
            offer(pick_stamp());
        calm = 1'b0;

        repeat (RANDOM_WORDS)
            offer(pick_stamp());

        calm = 1'b1;
        repeat (STEADY_WORDS)
            offer(pick_stamp());

        s_valid <= 1'b0;
        drain();
        repeat (2 * e2c_pkg::NUM_STAGES + 4) @(negedge aclk);

        $display("summary: %0d timestamps converted, %0d before 2000, %0d in 2100 or later",
                 dates_seen, early_seen, late_seen);
        $display("summary: %0d mismatches, %0d cycles", mismatches, cycle_count);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
